@@ rtl/sbsl_pkg.sv @@
// Shared constants, codes and types for the sorted byte set list.
package sbsl_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 8;
    localparam int OP_W     = 2;
    localparam int RANK_W   = 6;
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 7;
    localparam int RCMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int ECMP_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
    localparam int RANK_MAX = (1 << RANK_W) - 1;
    localparam int ECNT_MAX = (1 << ECNT_W) - 1;

    // Command codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd5;
    localparam logic [STAT_W-1:0] ST_BAD_RANK  = 3'd6;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

@@ rtl/sbsl_cell.sv @@
// One storage cell of the sorted chain: holds a key and its compare flags.
module sbsl_cell (
    input  logic                     i_clk,
    input  sbsl_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_valid,
    input  logic [sbsl_pkg::KEY_W-1:0] i_left_value,
    input  logic                     i_left_lt,
    input  logic [sbsl_pkg::KEY_W-1:0] i_right_value,
    output logic [sbsl_pkg::KEY_W-1:0] o_value,
    output logic                     o_lt,
    output logic                     o_eq
);
    import sbsl_pkg::*;

    logic [KEY_W-1:0] r_value;
    logic             r_lt;
    logic             r_eq;

    // Compare against the broadcast key, then shift on insert or delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_value < i_ctl.key);
            r_eq <= i_valid && (r_value == i_ctl.key);
        end
        if (i_ctl.ins) begin
            if (!i_left_lt) begin
                r_value <= i_left_value;
            end else if (!r_lt) begin
                r_value <= i_ctl.key;
            end
        end
        if (i_ctl.del) begin
            if (!r_lt) begin
                r_value <= i_right_value;
            end
        end
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

@@ rtl/sorted_byte_set_list.sv @@
// Top level of the sorted byte set list: sequencer, cell chain and result register.
// A command steps through the sequencer states compare (cells compare with the key) and
// execute (cell shift and result load); execute waits while the output holds an untaken result.
// The sequencer handles one command at a time. A command is accepted while an earlier
// result still waits in the output register. Reset (synchronous, active low) empties
// the store and drops any pending result.
module sorted_byte_set_list (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sbsl_pkg::OP_W-1:0]    i_opcode,
    input  logic [sbsl_pkg::KEY_W-1:0]   i_key,
    input  logic [sbsl_pkg::RANK_W-1:0]  i_rank_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sbsl_pkg::STAT_W-1:0]  o_status,
    output logic [sbsl_pkg::RANK_W-1:0]  o_rank,
    output logic [sbsl_pkg::KEY_W-1:0]   o_entry_value,
    output logic [sbsl_pkg::ECNT_W-1:0]  o_entry_count
);
    import sbsl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [RANK_W-1:0] r_ri;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic [KEY_W-1:0]  r_value, n_value;
    logic [ECNT_W-1:0] r_ecnt, n_ecnt;

    t_cell_ctl         cell_ctl;
    logic [KEY_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY:0] bnd;
    logic [CNT_W-1:0]  pos;
    logic [KEY_W-1:0]  read_value;
    logic              found;
    logic              commit;
    logic              do_ins;
    logic              do_del;
    logic              read_ok;
    logic              in_accept;
    logic [RCMP_W-1:0] pos_ext;
    logic [RCMP_W-1:0] ri_ext;
    logic [ECMP_W-1:0] cnt_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] left_value;
        logic             left_lt;
        logic [KEY_W-1:0] right_value;

        assign cell_valid[g] = (CNT_W'(g) < r_count);
        if (g == 0) begin : g_head
            assign left_value = '0;
            assign left_lt    = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        sbsl_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_valid       (cell_valid[g]),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    // Locate the insert point from the less-than boundary and pick the read entry
    always_comb begin
        bnd[0]        = !cell_lt[0];
        bnd[CAPACITY] = cell_lt[CAPACITY-1];
        for (int j = 1; j < CAPACITY; j++) begin
            bnd[j] = cell_lt[j-1] && !cell_lt[j];
        end
        pos = '0;
        for (int j = 0; j <= CAPACITY; j++) begin
            pos = pos | (bnd[j] ? CNT_W'(j) : '0);
        end
        read_value = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            read_value = read_value |
                ((RCMP_W'(r_ri) == RCMP_W'(j)) ? cell_value[j] : '0);
        end
    end

    assign found   = |cell_eq;
    assign pos_ext = RCMP_W'(pos);
    assign ri_ext  = RCMP_W'(r_ri);
    assign read_ok = (ri_ext < RCMP_W'(r_count));
    assign do_ins  = commit && (r_op == OP_INSERT) && !found &&
                     (r_count < CNT_W'(CAPACITY));
    assign do_del  = commit && (r_op == OP_DELETE) && found;

    // Drive the cells
    always_comb begin
        cell_ctl.cmp = (r_state == S_CMP);
        cell_ctl.ins = do_ins;
        cell_ctl.del = do_del;
        cell_ctl.key = r_key;
    end

    // Next count, result and sequencer state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_rank      = r_rank;
        n_value     = r_value;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_value     = '0;
                    n_rank      = (pos_ext > RCMP_W'(RANK_MAX)) ? RANK_W'(RANK_MAX)
                                                                : pos_ext[RANK_W-1:0];
                    if (do_ins) begin
                        n_count = r_count + 1'b1;
                    end else if (do_del) begin
                        n_count = r_count - 1'b1;
                    end
                    case (r_op)
                        OP_INSERT: begin
                            if (found) begin
                                n_status = ST_DUPLICATE;
                            end else if (do_ins) begin
                                n_status = ST_INSERTED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            n_status = found ? ST_DELETED : ST_NOT_FOUND;
                        end
                        OP_READ: begin
                            n_rank = r_ri;
                            if (read_ok) begin
                                n_status = ST_READ_OK;
                                n_value  = read_value;
                            end else begin
                                n_status = ST_BAD_RANK;
                            end
                        end
                        default: begin
                            n_status = ST_BAD_RANK;
                            n_rank   = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cnt_ext = ECMP_W'(n_count);
        n_ecnt  = (cnt_ext > ECMP_W'(ECNT_MAX)) ? ECNT_W'(ECNT_MAX) : cnt_ext[ECNT_W-1:0];
        if (!commit) begin
            n_ecnt = r_ecnt;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_ri  <= i_rank_index;
        end
        r_status <= n_status;
        r_rank   <= n_rank;
        r_value  <= n_value;
        r_ecnt   <= n_ecnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_rank        = r_rank;
    assign o_entry_value = r_value;
    assign o_entry_count = r_ecnt;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("held count beyond capacity");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CMP))
        else $error("accepted transaction did not start compare");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_count))
        else $error("count changed without a commit");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(cell_eq))
        else $error("more than one cell matched the key");

endmodule
